/* rtl/core/jrc_pkg.sv */
// Shared types and constants of the Jones rotation constraint core.
// Holds CORDIC widths, the arctangent table and the stage payload structs.
// No dependencies.
package jrc_pkg;

	// Field and datapath widths
	localparam int IN_W    = 32;
	localparam int SUM_W   = 34;
	localparam int XY_W    = 38;
	localparam int Z_W     = 35;
	localparam int OUT_W   = 17;
	localparam int TAB_LEN = 30;

	// Arctangent of 2^-i at 2^30 per radian, rounded down
	localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	// Angle constants at 2^30 per radian
	localparam logic signed [Z_W-1:0] ANG_PI      = 35'sd3373259426;
	localparam logic signed [Z_W-1:0] ANG_HALF_PI = 35'sd1686629713;

	// Start vector of the rotation CORDIC: 2^30 divided by the CORDIC gain
	localparam logic signed [XY_W-1:0] INV_GAIN = 38'sd652032874;

	// Output limits
	localparam logic signed [OUT_W-1:0] ANGLE_MAX = 17'sd51472;
	localparam logic signed [OUT_W-1:0] TRIG_MAX  = 17'sd32768;

	// One CORDIC vector with its angle accumulator
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_lane_t;

	// Payload of the vectoring chain: both circular terms side by side
	typedef struct packed {
		cordic_lane_t ll;
		cordic_lane_t rr;
		logic         ll_zero;
		logic         rr_zero;
		logic         last;
	} vec_pair_t;

	// Payload of the rotation chain
	typedef struct packed {
		cordic_lane_t            lane;
		logic                    neg;
		logic signed [OUT_W-1:0] angle;
		logic                    last;
	} rot_item_t;

	// One finished result
	typedef struct packed {
		logic signed [OUT_W-1:0] angle;
		logic signed [OUT_W-1:0] cos_val;
		logic signed [OUT_W-1:0] sin_val;
		logic                    last;
	} result_t;

endpackage

/* rtl/core/jrc_vec_cell.sv */
// One micro-rotation cell of the vectoring CORDIC chain.
// Rotates both circular-term vectors toward the x axis; uses jrc_pkg.
module jrc_vec_cell #(
	parameter int SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  jrc_pkg::vec_pair_t  pair_i,
	output logic                valid_o,
	output jrc_pkg::vec_pair_t  pair_o
);

	localparam logic signed [jrc_pkg::Z_W-1:0] ATAN_STEP =
		jrc_pkg::Z_W'(jrc_pkg::ATAN_TAB[SHIFT]);

	logic               valid_q;
	jrc_pkg::vec_pair_t pair_q;
	jrc_pkg::vec_pair_t pair_d;

	// Drive y toward zero, accumulate the angle
	function automatic jrc_pkg::cordic_lane_t vec_step(jrc_pkg::cordic_lane_t a);
		logic signed [jrc_pkg::XY_W-1:0] dx;
		logic signed [jrc_pkg::XY_W-1:0] dy;
		jrc_pkg::cordic_lane_t           r;
		dx = $signed(a.y) >>> SHIFT;
		dy = $signed(a.x) >>> SHIFT;
		r  = a;
		if (!a.y[jrc_pkg::XY_W-1]) begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + ATAN_STEP;
		end else begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - ATAN_STEP;
		end
		return r;
	endfunction

	always_comb begin
		pair_d    = pair_i;
		pair_d.ll = vec_step(pair_i.ll);
		pair_d.rr = vec_step(pair_i.rr);
	end

	// Advance the valid flag with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			pair_q <= pair_d;
		end
	end

	assign valid_o = valid_q;
	assign pair_o  = pair_q;

endmodule

/* rtl/core/jrc_rot_cell.sv */
// One micro-rotation cell of the rotation CORDIC chain.
// Turns the vector by the residual angle to form cosine and sine; uses jrc_pkg.
module jrc_rot_cell #(
	parameter int SHIFT = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_i,
	input  jrc_pkg::rot_item_t  item_i,
	output logic                valid_o,
	output jrc_pkg::rot_item_t  item_o
);

	localparam logic signed [jrc_pkg::Z_W-1:0] ATAN_STEP =
		jrc_pkg::Z_W'(jrc_pkg::ATAN_TAB[SHIFT]);

	logic                              valid_q;
	jrc_pkg::rot_item_t                item_q;
	jrc_pkg::rot_item_t                item_d;
	logic signed [jrc_pkg::XY_W-1:0]   dx;
	logic signed [jrc_pkg::XY_W-1:0]   dy;

	// Drive the residual angle toward zero
	always_comb begin
		dx     = $signed(item_i.lane.y) >>> SHIFT;
		dy     = $signed(item_i.lane.x) >>> SHIFT;
		item_d = item_i;
		if (!item_i.lane.z[jrc_pkg::Z_W-1]) begin
			item_d.lane.x = item_i.lane.x - dx;
			item_d.lane.y = item_i.lane.y + dy;
			item_d.lane.z = item_i.lane.z - ATAN_STEP;
		end else begin
			item_d.lane.x = item_i.lane.x + dx;
			item_d.lane.y = item_i.lane.y - dy;
			item_d.lane.z = item_i.lane.z + ATAN_STEP;
		end
	end

	// Advance the valid flag with the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_i;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= item_d;
		end
	end

	assign valid_o = valid_q;
	assign item_o  = item_q;

endmodule

/* rtl/core/jrc_out_fifo.sv */
// Two-entry result buffer between the CORDIC pipeline and the output channel.
// Lets the pipeline take one more transaction while a result waits; uses jrc_pkg.
module jrc_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jrc_pkg::result_t  data_i,
	output logic              full,
	output logic              valid_o,
	input  logic              ready_i,
	output jrc_pkg::result_t  data_o
);

	jrc_pkg::result_t mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             pop;

	assign full    = (count_q == 2'd2);
	assign valid_o = (count_q != 2'd0);
	assign pop     = valid_o && ready_i;
	assign data_o  = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Store the incoming result
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= data_i;
		end
	end

endmodule

/* rtl/core/jones_rotation_constraint_core.sv */
// Pipeline: an accepted transaction passes through two chains of CORDIC cells (vectoring, then
// rotation) plus five fixed stages, and then through the output buffer to out_valid.
// Throughput: one transaction per cycle; the pipeline stalls only when both entries
// of the output buffer hold results not yet taken.
// Reset: arst_n clears all valid flags and the output buffer; no item is in flight after it.
// Rotation-constraint core: top level, uses jrc_pkg, jrc_vec_cell, jrc_rot_cell, jrc_out_fifo.
module jones_rotation_constraint_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [jrc_pkg::IN_W-1:0] m00_re,
	input  logic signed [jrc_pkg::IN_W-1:0] m00_im,
	input  logic signed [jrc_pkg::IN_W-1:0] m01_re,
	input  logic signed [jrc_pkg::IN_W-1:0] m01_im,
	input  logic signed [jrc_pkg::IN_W-1:0] m10_re,
	input  logic signed [jrc_pkg::IN_W-1:0] m10_im,
	input  logic signed [jrc_pkg::IN_W-1:0] m11_re,
	input  logic signed [jrc_pkg::IN_W-1:0] m11_im,
	input  logic                            last_item,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [jrc_pkg::OUT_W-1:0] angle,
	output logic signed [jrc_pkg::OUT_W-1:0] cos_val,
	output logic signed [jrc_pkg::OUT_W-1:0] sin_val,
	output logic                            last_result
);

	localparam int RUN = (CORDIC_STAGES < jrc_pkg::TAB_LEN) ? CORDIC_STAGES : jrc_pkg::TAB_LEN;
	localparam int SW  = jrc_pkg::SUM_W;
	localparam int XW  = jrc_pkg::XY_W;
	localparam int ZW  = jrc_pkg::Z_W;
	localparam int OW  = jrc_pkg::OUT_W;

	localparam logic signed [ZW-1:0] RND16   = ZW'(32768);
	localparam logic signed [ZW-1:0] ANG_HI  = ZW'(jrc_pkg::ANGLE_MAX);
	localparam logic signed [ZW-1:0] ANG_LO  = -ANG_HI;
	localparam logic signed [XW-1:0] RND15   = XW'(16384);
	localparam logic signed [XW-1:0] TRIG_HI = XW'(jrc_pkg::TRIG_MAX);
	localparam logic signed [XW-1:0] TRIG_LO = -TRIG_HI;

	logic en;
	logic fifo_full;

	// Stage 1: circular terms
	logic signed [SW-1:0] ll_re_d, ll_im_d, rr_re_d, rr_im_d;
	logic signed [SW-1:0] ll_re_s1, ll_im_s1, rr_re_s1, rr_im_s1;
	logic                 last_s1;
	logic                 valid_s1;

	// Stage 2: quadrant pre-rotation
	jrc_pkg::vec_pair_t pair_d2;
	jrc_pkg::vec_pair_t pair_s2;
	logic               valid_s2;

	// Vectoring chain
	jrc_pkg::vec_pair_t vec_pipe [RUN+1];
	logic [RUN:0]       vec_valid;

	// Stage 3: half difference of the two angles
	logic signed [ZW-1:0] z_ll, z_rr, z_diff, h_d3;
	logic signed [ZW-1:0] h_s3;
	logic                 last_s3;
	logic                 valid_s3;

	// Stage 4: angle output and fold into the right half plane
	logic signed [ZW-1:0] ang_round;
	jrc_pkg::rot_item_t   item_d4;
	jrc_pkg::rot_item_t   item_s4;
	logic                 valid_s4;

	// Rotation chain
	jrc_pkg::rot_item_t   rot_pipe [RUN+1];
	logic [RUN:0]         rot_valid;

	// Stage 5: undo the fold
	logic signed [XW-1:0] x_s5, y_s5;
	logic signed [OW-1:0] angle_s5;
	logic                 last_s5;
	logic                 valid_s5;

	jrc_pkg::result_t     res_push;
	jrc_pkg::result_t     res_out;

	// Turn a left-half-plane vector by a quarter turn
	function automatic jrc_pkg::cordic_lane_t pre_rot(logic signed [SW-1:0] re,
	                                                  logic signed [SW-1:0] im);
		logic signed [XW-1:0]  x;
		logic signed [XW-1:0]  y;
		jrc_pkg::cordic_lane_t r;
		x   = XW'(re);
		y   = XW'(im);
		r.x = x;
		r.y = y;
		r.z = '0;
		if (x[XW-1]) begin
			if (!y[XW-1]) begin
				r.x = y;
				r.y = -x;
				r.z = jrc_pkg::ANG_HALF_PI;
			end else begin
				r.x = -y;
				r.y = x;
				r.z = -jrc_pkg::ANG_HALF_PI;
			end
		end
		return r;
	endfunction

	// Round to Q1.15 and clamp
	function automatic logic signed [OW-1:0] trig_out(logic signed [XW-1:0] v);
		logic signed [XW-1:0] r;
		r = (v + RND15) >>> 15;
		if (r > TRIG_HI) begin
			r = TRIG_HI;
		end else if (r < TRIG_LO) begin
			r = TRIG_LO;
		end
		return OW'(r);
	endfunction

	// Advance the whole pipeline unless the output buffer is full
	assign en       = !fifo_full;
	assign in_ready = en;

	// Form the circular terms
	always_comb begin
		ll_re_d = SW'(m00_re) + SW'(m11_re) + SW'(m01_im) - SW'(m10_im);
		ll_im_d = SW'(m00_im) + SW'(m11_im) - SW'(m01_re) + SW'(m10_re);
		rr_re_d = SW'(m00_re) + SW'(m11_re) - SW'(m01_im) + SW'(m10_im);
		rr_im_d = SW'(m00_im) + SW'(m11_im) + SW'(m01_re) - SW'(m10_re);
	end

	// Pre-rotate and flag zero vectors
	always_comb begin
		pair_d2.ll      = pre_rot(ll_re_s1, ll_im_s1);
		pair_d2.rr      = pre_rot(rr_re_s1, rr_im_s1);
		pair_d2.ll_zero = (ll_re_s1 == '0) && (ll_im_s1 == '0);
		pair_d2.rr_zero = (rr_re_s1 == '0) && (rr_im_s1 == '0);
		pair_d2.last    = last_s1;
	end

	// Halve the angle difference; a zero vector has angle zero
	always_comb begin
		z_ll   = vec_pipe[RUN].ll_zero ? '0 : vec_pipe[RUN].ll.z;
		z_rr   = vec_pipe[RUN].rr_zero ? '0 : vec_pipe[RUN].rr.z;
		z_diff = z_ll - z_rr;
		h_d3   = z_diff >>> 1;
	end

	// Round and clamp the angle, fold the rotation input
	always_comb begin
		ang_round      = (h_s3 + RND16) >>> 16;
		item_d4.last   = last_s3;
		item_d4.lane.x = jrc_pkg::INV_GAIN;
		item_d4.lane.y = '0;
		item_d4.lane.z = h_s3;
		item_d4.neg    = 1'b0;
		if (ang_round > ANG_HI) begin
			item_d4.angle = OW'(ANG_HI);
		end else if (ang_round < ANG_LO) begin
			item_d4.angle = OW'(ANG_LO);
		end else begin
			item_d4.angle = OW'(ang_round);
		end
		if (h_s3 > jrc_pkg::ANG_HALF_PI) begin
			item_d4.lane.z = h_s3 - jrc_pkg::ANG_PI;
			item_d4.neg    = 1'b1;
		end else if (h_s3 < -jrc_pkg::ANG_HALF_PI) begin
			item_d4.lane.z = h_s3 + jrc_pkg::ANG_PI;
			item_d4.neg    = 1'b1;
		end
	end

	// Pipeline valid flags outside the cell chains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= vec_valid[RUN];
			valid_s4 <= valid_s3;
			valid_s5 <= rot_valid[RUN];
		end
	end

	// Pipeline payload outside the cell chains
	always_ff @(posedge clk) begin
		if (en) begin
			ll_re_s1 <= ll_re_d;
			ll_im_s1 <= ll_im_d;
			rr_re_s1 <= rr_re_d;
			rr_im_s1 <= rr_im_d;
			last_s1  <= last_item;
			pair_s2  <= pair_d2;
			h_s3     <= h_d3;
			last_s3  <= vec_pipe[RUN].last;
			item_s4  <= item_d4;
			x_s5     <= rot_pipe[RUN].neg ? -rot_pipe[RUN].lane.x : rot_pipe[RUN].lane.x;
			y_s5     <= rot_pipe[RUN].neg ? -rot_pipe[RUN].lane.y : rot_pipe[RUN].lane.y;
			angle_s5 <= rot_pipe[RUN].angle;
			last_s5  <= rot_pipe[RUN].last;
		end
	end

	// Vectoring cells, one micro-rotation each
	assign vec_pipe[0]  = pair_s2;
	assign vec_valid[0] = valid_s2;

	for (genvar k = 0; k < RUN; k++) begin : g_vec
		jrc_vec_cell #(
			.SHIFT (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (vec_valid[k]),
			.pair_i  (vec_pipe[k]),
			.valid_o (vec_valid[k+1]),
			.pair_o  (vec_pipe[k+1])
		);
	end

	// Rotation cells, one micro-rotation each
	assign rot_pipe[0]  = item_s4;
	assign rot_valid[0] = valid_s4;

	for (genvar k = 0; k < RUN; k++) begin : g_rot
		jrc_rot_cell #(
			.SHIFT (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid_i (rot_valid[k]),
			.item_i  (rot_pipe[k]),
			.valid_o (rot_valid[k+1]),
			.item_o  (rot_pipe[k+1])
		);
	end

	// Round the trig values into the result buffer
	always_comb begin
		res_push.angle   = angle_s5;
		res_push.cos_val = trig_out(x_s5);
		res_push.sin_val = trig_out(y_s5);
		res_push.last    = last_s5;
	end

	jrc_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (en && valid_s5),
		.data_i  (res_push),
		.full    (fifo_full),
		.valid_o (out_valid),
		.ready_i (out_ready),
		.data_o  (res_out)
	);

	assign angle       = res_out.angle;
	assign cos_val     = res_out.cos_val;
	assign sin_val     = res_out.sin_val;
	assign last_result = res_out.last;

`ifndef SYNTHESIS
	// A stalled pipeline keeps its last stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(valid_s5))
		else $error("pipeline moved while the output buffer was full");

	// Back-pressure only comes from waiting results
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result pending");

	// A finished item reaches the output channel
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 && in_ready |=> out_valid)
		else $error("result pushed but not presented");
`endif

endmodule
